// ----- src/csvft_pkg.sv -----
// ----------------------------------------------------------------------------
// csvft_pkg
// Shared constants, codes and helpers for the CSV field tokenizer.
// ----------------------------------------------------------------------------
package csvft_pkg;

    // Field buffer depth in bytes (legal range 1 to 65534)
    localparam int FIELD_MAX = 32;
    localparam int ADDR_W    = (FIELD_MAX > 1) ? $clog2(FIELD_MAX) : 1;
    localparam int CNT_W     = $clog2(FIELD_MAX + 1);
    localparam int LEN_W     = 16;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_IDX_DELIMITER = 1'b0;
    localparam logic [7:0] DELIMITER_RESET = 8'd44;

    // Result kinds
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_EOR   = 2'd2;
    localparam logic [1:0] KIND_EOI   = 2'd3;

    // Quote modes
    localparam logic [1:0] QUOTE_NONE   = 2'd0;
    localparam logic [1:0] QUOTE_DOUBLE = 2'd1;
    localparam logic [1:0] QUOTE_SINGLE = 2'd2;

    // Characters
    localparam logic [7:0] CHR_NUL    = 8'h00;
    localparam logic [7:0] CHR_TAB    = 8'h09;
    localparam logic [7:0] CHR_NL     = 8'h0A;
    localparam logic [7:0] CHR_VT     = 8'h0B;
    localparam logic [7:0] CHR_FF     = 8'h0C;
    localparam logic [7:0] CHR_CR     = 8'h0D;
    localparam logic [7:0] CHR_SPACE  = 8'h20;
    localparam logic [7:0] CHR_DQUOTE = 8'h22;
    localparam logic [7:0] CHR_SQUOTE = 8'h27;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_BYTE = 4'b0100,
        ST_PUT  = 4'b1000
    } state_t;

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == CHR_SPACE) || (c == CHR_TAB) || (c == CHR_NL) ||
                   (c == CHR_VT) || (c == CHR_FF) || (c == CHR_CR);
    endfunction

endpackage

// ----- src/csvft_ram.sv -----
// ----------------------------------------------------------------------------
// csvft_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module csvft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/csv_field_tokenizer.sv -----
// ----------------------------------------------------------------------------
// csv_field_tokenizer
// Splits a byte stream into CSV fields and records.
// ----------------------------------------------------------------------------
// Text enters one byte per input word; a word with s_tlast set marks the end of
// the stream and its byte is ignored. Null bytes are skipped and blanks or tabs
// before a field are dropped. A field may open with a double or single quote,
// in which a doubled quote is one literal quote and the delimiter only ends the
// field after the closing quote. A newline ends the field and the record. Field
// bytes go into a FIELD_MAX-byte store; once a field is complete it is read
// back and sent one output word per byte (or one empty-field word), followed
// by end-of-record and end-of-input words where due. m_tlast flags the last
// output word caused by an input word. An input word that yields no output
// leaves the block idle. Each stored byte of a field goes through the store's
// single read port: the read is issued, then the output register is loaded
// once it is free; each empty-field, end-of-record or end-of-input word is
// loaded on its own. New input is taken only once all output of the previous
// word sits in, or has left, the output register.
// The delimiter (register 0, reset ',') may only be written while idle.
// ----------------------------------------------------------------------------
module csv_field_tokenizer (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    // Input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,   // [7:0] data_byte
    input  logic                                 s_tlast,   // end_of_input

    // Result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [7:0]                           m_tdata,   // [7:0] out_byte
    output logic [3:0]                           m_tuser,   // [1:0] kind, [2] field_end,
                                                            // [3] truncated
    output logic                                 m_tlast,   // last

    // Configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [csvft_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [csvft_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [csvft_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                 pready
);

    import csvft_pkg::*;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [7:0] delimiter_reg;
    logic       cfg_hit;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[CFG_ADDR_W-1:2] == REG_IDX_DELIMITER);
    assign cfg_write = psel && penable && pwrite && pready && cfg_hit;
    assign prdata    = cfg_hit ? {{(CFG_DATA_W-8){1'b0}}, delimiter_reg}
                               : {CFG_DATA_W{1'b0}};

    // ------------------------------------------------------------------
    // Field state
    // ------------------------------------------------------------------
    logic             at_start_reg,    at_start_next;
    logic [1:0]       open_quote_reg,  open_quote_next;
    logic [LEN_W-1:0] quote_pos_reg,   quote_pos_next;
    logic             quote_pend_reg,  quote_pend_next;
    logic [LEN_W-1:0] raw_len_reg,     raw_len_next;
    logic [LEN_W-1:0] trim_len_reg,    trim_len_next;
    logic             overflow_reg,    overflow_next;
    logic             record_open_reg, record_open_next;

    // Drain sequencer
    state_t           state_reg,       state_next;
    logic [ADDR_W-1:0] idx_reg,        idx_next;
    logic [CNT_W-1:0] cnt_reg,         cnt_next;
    logic             trunc_reg,       trunc_next;
    logic             pend_empty_reg,  pend_empty_next;
    logic             pend_rec_reg,    pend_rec_next;
    logic             pend_eoi_reg,    pend_eoi_next;

    // Output register
    logic             m_valid_reg;
    logic [7:0]       m_data_reg;
    logic [3:0]       m_user_reg;
    logic             m_last_reg;

    // Step decode
    logic             accept;
    logic [7:0]       c;
    logic [7:0]       qch;
    logic             done;
    logic             do_emit;
    logic             do_rec;
    logic             do_eoi;
    logic             do_clear;
    logic             do_append;
    logic [LEN_W-1:0] emit_len;
    logic [CNT_W-1:0] emit_cnt;
    logic             emit_trunc;
    logic             ram_we;
    logic [7:0]       ram_rdata;

    // Output load
    logic             slot_free;
    logic             out_load;
    logic [7:0]       out_data;
    logic [1:0]       out_kind;
    logic             out_fend;
    logic             out_trunc;
    logic             out_last;
    logic             last_byte;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign c        = s_tdata;

    // Length of the finished field: cut at the closing quote, else trimmed
    assign emit_len   = quote_pend_reg ? quote_pos_reg : trim_len_reg;
    assign emit_trunc = overflow_reg && (emit_len > LEN_W'(FIELD_MAX));
    assign emit_cnt   = (emit_len > LEN_W'(FIELD_MAX)) ? CNT_W'(FIELD_MAX)
                                                        : emit_len[CNT_W-1:0];

    always_comb begin
        qch = (open_quote_reg == QUOTE_DOUBLE) ? CHR_DQUOTE :
              (open_quote_reg == QUOTE_SINGLE) ? CHR_SQUOTE : CHR_NUL;
    end

    // ------------------------------------------------------------------
    // Per-byte parse: decide results and next field state
    // ------------------------------------------------------------------
    always_comb begin
        at_start_next    = at_start_reg;
        open_quote_next  = open_quote_reg;
        quote_pos_next   = quote_pos_reg;
        quote_pend_next  = quote_pend_reg;
        raw_len_next     = raw_len_reg;
        trim_len_next    = trim_len_reg;
        overflow_next    = overflow_reg;
        record_open_next = record_open_reg;
        done      = 1'b0;
        do_emit   = 1'b0;
        do_rec    = 1'b0;
        do_eoi    = 1'b0;
        do_clear  = 1'b0;
        do_append = 1'b0;
        ram_we    = 1'b0;

        if (accept) begin
            if (s_tlast) begin
                // Flush pending field, close the record, mark end of stream
                do_emit          = (raw_len_reg != '0);
                do_rec           = record_open_reg || (raw_len_reg != '0);
                do_eoi           = 1'b1;
                do_clear         = 1'b1;
                record_open_next = 1'b0;
            end else if (c != CHR_NUL) begin
                if (at_start_reg) begin
                    if (c == CHR_NL) begin
                        // Blank line: end of record only
                        do_rec           = 1'b1;
                        record_open_next = 1'b0;
                        done             = 1'b1;
                    end else if (c != delimiter_reg && (c == CHR_SPACE || c == CHR_TAB)) begin
                        done = 1'b1;
                    end else begin
                        at_start_next = 1'b0;
                        if (c == CHR_DQUOTE || c == CHR_SQUOTE) begin
                            open_quote_next = (c == CHR_DQUOTE) ? QUOTE_DOUBLE
                                                                : QUOTE_SINGLE;
                            done = 1'b1;
                        end
                    end
                end
                if (!done) begin
                    if (c == CHR_NL) begin
                        do_emit          = 1'b1;
                        do_rec           = 1'b1;
                        do_clear         = 1'b1;
                        record_open_next = 1'b0;
                    end else if ((open_quote_reg == QUOTE_NONE || quote_pend_reg) &&
                                 c == delimiter_reg) begin
                        do_emit          = 1'b1;
                        do_clear         = 1'b1;
                        record_open_next = 1'b1;
                    end else if (qch != CHR_NUL && c == qch) begin
                        if (quote_pend_reg && raw_len_reg != '0 &&
                            quote_pos_reg == raw_len_reg - LEN_W'(1)) begin
                            // Doubled quote: the stored quote stands for one
                            quote_pend_next = 1'b0;
                            quote_pos_next  = '0;
                        end else begin
                            quote_pend_next = 1'b1;
                            quote_pos_next  = raw_len_reg;
                            do_append       = 1'b1;
                        end
                    end else begin
                        if (quote_pend_reg && !is_space(c)) begin
                            quote_pend_next = 1'b0;
                            quote_pos_next  = '0;
                        end
                        do_append = 1'b1;
                    end
                end
            end
        end

        if (do_append) begin
            if (raw_len_reg < LEN_W'(FIELD_MAX)) begin
                ram_we = 1'b1;
            end else begin
                overflow_next = 1'b1;
            end
            if (raw_len_reg != {LEN_W{1'b1}}) begin
                raw_len_next = raw_len_reg + LEN_W'(1);
            end
            if (!is_space(c)) begin
                trim_len_next = raw_len_next;
            end
        end

        if (do_clear) begin
            at_start_next   = 1'b1;
            open_quote_next = QUOTE_NONE;
            quote_pos_next  = '0;
            quote_pend_next = 1'b0;
            raw_len_next    = '0;
            trim_len_next   = '0;
            overflow_next   = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Field store
    // ------------------------------------------------------------------
    csvft_ram #(
        .WIDTH (8),
        .DEPTH (FIELD_MAX)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (raw_len_reg[ADDR_W-1:0]),
        .wdata (c),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Drain sequencer and output load
    // ------------------------------------------------------------------
    assign slot_free = !m_valid_reg || m_tready;
    assign last_byte = ((CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg);

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        trunc_next      = trunc_reg;
        pend_empty_next = pend_empty_reg;
        pend_rec_next   = pend_rec_reg;
        pend_eoi_next   = pend_eoi_reg;
        out_load  = 1'b0;
        out_data  = 8'h00;
        out_kind  = KIND_BYTE;
        out_fend  = 1'b0;
        out_trunc = 1'b0;
        out_last  = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    idx_next        = '0;
                    cnt_next        = emit_cnt;
                    trunc_next      = emit_trunc;
                    pend_empty_next = do_emit && (emit_cnt == '0);
                    pend_rec_next   = do_rec;
                    pend_eoi_next   = do_eoi;
                    if (do_emit && emit_cnt != '0) begin
                        state_next = ST_READ;
                    end else if (do_emit || do_rec || do_eoi) begin
                        state_next = ST_PUT;
                    end
                end
            end
            ST_READ: begin
                // Read data valid next cycle
                state_next = ST_BYTE;
            end
            ST_BYTE: begin
                if (slot_free) begin
                    out_load  = 1'b1;
                    out_data  = ram_rdata;
                    out_kind  = KIND_BYTE;
                    out_fend  = last_byte;
                    out_trunc = trunc_reg;
                    out_last  = last_byte && !pend_rec_reg && !pend_eoi_reg;
                    if (last_byte) begin
                        state_next = (pend_rec_reg || pend_eoi_reg) ? ST_PUT : ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + ADDR_W'(1);
                        state_next = ST_READ;
                    end
                end
            end
            ST_PUT: begin
                if (slot_free) begin
                    out_load = 1'b1;
                    if (pend_empty_reg) begin
                        out_kind        = KIND_EMPTY;
                        out_fend        = 1'b1;
                        out_last        = !pend_rec_reg && !pend_eoi_reg;
                        pend_empty_next = 1'b0;
                    end else if (pend_rec_reg) begin
                        out_kind      = KIND_EOR;
                        out_last      = !pend_eoi_reg;
                        pend_rec_next = 1'b0;
                    end else begin
                        out_kind      = KIND_EOI;
                        out_last      = 1'b1;
                        pend_eoi_next = 1'b0;
                    end
                    if (out_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delimiter_reg   <= DELIMITER_RESET;
            at_start_reg    <= 1'b1;
            open_quote_reg  <= QUOTE_NONE;
            quote_pos_reg   <= '0;
            quote_pend_reg  <= 1'b0;
            raw_len_reg     <= '0;
            trim_len_reg    <= '0;
            overflow_reg    <= 1'b0;
            record_open_reg <= 1'b0;
            state_reg       <= ST_IDLE;
            idx_reg         <= '0;
            pend_empty_reg  <= 1'b0;
            pend_rec_reg    <= 1'b0;
            pend_eoi_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_write) begin
                delimiter_reg <= pwdata[7:0];
            end
            at_start_reg    <= at_start_next;
            open_quote_reg  <= open_quote_next;
            quote_pos_reg   <= quote_pos_next;
            quote_pend_reg  <= quote_pend_next;
            raw_len_reg     <= raw_len_next;
            trim_len_reg    <= trim_len_next;
            overflow_reg    <= overflow_next;
            record_open_reg <= record_open_next;
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            pend_empty_reg  <= pend_empty_next;
            pend_rec_reg    <= pend_rec_next;
            pend_eoi_reg    <= pend_eoi_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: no reset needed
    always_ff @(posedge aclk) begin
        cnt_reg   <= cnt_next;
        trunc_reg <= trunc_next;
        if (out_load) begin
            m_data_reg <= out_data;
            m_user_reg <= {out_trunc, out_fend, out_kind};
            m_last_reg <= out_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ----- tb/sv/csv_field_tokenizer_chk.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csv_field_tokenizer_chk
// Stream checker for the CSV field tokenizer.
// ----------------------------------------------------------------------------
// Watches the input, result and register channels. Every accepted input word
// runs through a local tokenizer model, and the result words it must cause
// are queued. Every accepted result word is compared field by field with the
// oldest queued one.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_chk (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] data_byte
    input  logic                             s_tlast,   // end_of_input
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [7:0]                       m_tdata,   // [7:0] out_byte
    input  logic [3:0]                       m_tuser,   // [1:0] kind, [2] field_end,
                                                        // [3] truncated
    input  logic                             m_tlast,   // last
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [csvft_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [csvft_pkg::CFG_DATA_W-1:0] pwdata,
    input  logic                             pready,
    output int                               mismatches,
    output int                               outstanding
);

    import csvft_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] DELIM_ADDR = CFG_ADDR_W'(4 * REG_IDX_DELIMITER);

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       field_end;
        logic       truncated;
        logic       last;
    } token_t;

    token_t      tokens_due[$];
    token_t      got;
    int          errs = 0;

    // Model state
    logic [7:0]  delim;
    logic [7:0]  fbuf [FIELD_MAX];
    logic        at_start;
    logic        rec_open;
    logic [1:0]  quote_mode;
    logic        quote_hold;
    logic [15:0] quote_at;
    logic [15:0] raw_len;
    logic [15:0] trim_len;
    logic        ovf;

    function automatic bit is_ws(input logic [7:0] c);
        return c == CHR_SPACE || c == CHR_TAB || c == CHR_NL ||
               c == CHR_VT || c == CHR_FF || c == CHR_CR;
    endfunction

    task automatic queue_token(input logic [7:0] d, input logic [1:0] k,
                               input logic fe, input logic tr);
        token_t t;
        t.data      = d;
        t.kind      = k;
        t.field_end = fe;
        t.truncated = tr;
        t.last      = 1'b0;
        tokens_due.insert(tokens_due.size(), t);
    endtask

    task automatic reset_field();
        at_start   = 1'b1;
        quote_mode = QUOTE_NONE;
        quote_hold = 1'b0;
        quote_at   = '0;
        raw_len    = '0;
        trim_len   = '0;
        ovf        = 1'b0;
    endtask

    // Queue the finished field: cut at a pending closing quote, else trimmed.
    task automatic flush_field();
        int   len;
        int   cnt;
        logic tr;
        len = quote_hold ? int'(quote_at) : int'(trim_len);
        tr  = ovf && (len > FIELD_MAX);
        cnt = (len > FIELD_MAX) ? FIELD_MAX : len;
        if (cnt == 0) begin
            queue_token(8'h00, KIND_EMPTY, 1'b1, 1'b0);
        end else begin
            for (int i = 0; i < cnt; i++)
                queue_token(fbuf[i], KIND_BYTE, (i + 1) == cnt, tr);
        end
        rec_open = 1'b1;
        reset_field();
    endtask

    task automatic store_byte(input logic [7:0] c);
        if (raw_len < FIELD_MAX)
            fbuf[raw_len] = c;
        else
            ovf = 1'b1;
        if (raw_len != 16'hFFFF)
            raw_len = raw_len + 16'd1;
        if (!is_ws(c))
            trim_len = raw_len;
    endtask

    task automatic tokenize_word(input logic [7:0] c, input logic eoi);
        int         first;
        logic       done;
        logic [7:0] qch;
        first = tokens_due.size();
        if (eoi) begin
            if (raw_len != 0)
                flush_field();
            if (rec_open)
                queue_token(8'h00, KIND_EOR, 1'b0, 1'b0);
            queue_token(8'h00, KIND_EOI, 1'b0, 1'b0);
            reset_field();
            rec_open = 1'b0;
        end else if (c != CHR_NUL) begin
            done = 1'b0;
            if (at_start) begin
                if (c == CHR_NL) begin
                    queue_token(8'h00, KIND_EOR, 1'b0, 1'b0);
                    rec_open = 1'b0;
                    done     = 1'b1;
                end else if (c != delim && (c == CHR_SPACE || c == CHR_TAB)) begin
                    done = 1'b1;
                end else begin
                    at_start = 1'b0;
                    if (c == CHR_DQUOTE || c == CHR_SQUOTE) begin
                        quote_mode = (c == CHR_DQUOTE) ? QUOTE_DOUBLE : QUOTE_SINGLE;
                        done       = 1'b1;
                    end
                end
            end
            if (!done) begin
                qch = (quote_mode == QUOTE_DOUBLE) ? CHR_DQUOTE :
                      (quote_mode == QUOTE_SINGLE) ? CHR_SQUOTE : CHR_NUL;
                if (c == CHR_NL) begin
                    flush_field();
                    queue_token(8'h00, KIND_EOR, 1'b0, 1'b0);
                    rec_open = 1'b0;
                end else if ((quote_mode == QUOTE_NONE || quote_hold) && c == delim) begin
                    flush_field();
                end else if (qch != CHR_NUL && c == qch) begin
                    // second quote right after a first one is an escape
                    if (quote_hold && raw_len != 0 && quote_at == raw_len - 16'd1) begin
                        quote_hold = 1'b0;
                        quote_at   = '0;
                    end else begin
                        quote_hold = 1'b1;
                        quote_at   = raw_len;
                        store_byte(c);
                    end
                end else begin
                    if (quote_hold && !is_ws(c)) begin
                        quote_hold = 1'b0;
                        quote_at   = '0;
                    end
                    store_byte(c);
                end
            end
        end
        if (tokens_due.size() > first)
            tokens_due[tokens_due.size() - 1].last = 1'b1;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned seen);
        if (want != seen) begin
            $error("%s: expected %0h, got %0h", name, want, seen);
            errs++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            delim = DELIMITER_RESET;
            reset_field();
            rec_open = 1'b0;
            tokens_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (tokens_due.size() == 0) begin
                    $error("unexpected result word: out_byte %0h tuser %0h last %0b",
                           m_tdata, m_tuser, m_tlast);
                    errs++;
                end else begin
                    got = tokens_due.pop_front();
                    check_field("out_byte",  got.data,      m_tdata);
                    check_field("kind",      got.kind,      m_tuser[1:0]);
                    check_field("field_end", got.field_end, m_tuser[2]);
                    check_field("truncated", got.truncated, m_tuser[3]);
                    check_field("last",      got.last,      m_tlast);
                end
            end
            if (s_tvalid && s_tready)
                tokenize_word(s_tdata, s_tlast);
            if (psel && penable && pwrite && pready && paddr == DELIM_ADDR)
                delim = pwdata[7:0];
        end
        mismatches  <= errs;
        outstanding <= tokens_due.size();
    end

endmodule

// ----- tb/sv/csv_field_tokenizer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csv_field_tokenizer_tb
// Top-level testbench for the CSV field tokenizer.
// ----------------------------------------------------------------------------
// Feeds a short directed text covering quoting, escapes, blank lines, empty
// fields, trimming and end of stream, then random records with random field
// shapes (plain, quoted, long enough to overflow the store, whitespace only)
// mixed with raw noise, under several delimiter settings written between
// phases. The sender runs in bursts, the receiver stalls on its own pattern
// and holds off once for a long stretch. The checker beside the block
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_tb;
    import csvft_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] DELIM_ADDR = CFG_ADDR_W'(4 * REG_IDX_DELIMITER);
    localparam int PHASE_ITEMS   = 40;      // input words per random phase
    localparam int HOLD_CYCLES   = 400;     // long receiver hold-off
    localparam int SETTLE_CYCLES = 8;       // quiet time before a register write
    localparam int DRAIN_CYCLES  = 20;      // quiet time before the verdict
    localparam int CYCLE_LIMIT   = 400000;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;   // [7:0] data_byte
    logic                  s_tlast   = 1'b0; // end_of_input
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;          // [7:0] out_byte
    logic [3:0]            m_tuser;          // [1:0] kind, [2] field_end, [3] truncated
    logic                  m_tlast;          // last
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr     = '0;
    logic [CFG_DATA_W-1:0] pwdata    = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int         errors;
    int         outstanding;
    int         cycle_cnt   = 0;
    int         burst_left  = 0;
    int         items_sent  = 0;
    logic [7:0] cur_delim   = DELIMITER_RESET;
    logic       hold_req    = 1'b0;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    csv_field_tokenizer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    csv_field_tokenizer_chk i_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .mismatches  (errors),
        .outstanding (outstanding)
    );

    // Watchdog: a hung handshake or a lost result word ends here.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("csv_field_tokenizer_tb: FAIL");
            $finish;
        end
    end

    // Receiver: switch between free-running, light and heavy stall modes.
    // Once the stimulus asks for it, hold off for a long stretch so that the
    // block backs up and stalls its input while words keep being offered.
    initial begin
        int  mode;
        int  mode_left;
        bit  hold_done;
        mode      = 0;
        mode_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else if (aresetn) begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 60);
                end
                mode_left--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) == 1);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Offer one word and hold it until taken. Most bursts end in an idle gap, with
    // valid dropped; the others run straight into the next burst.
    task automatic send_word(input logic [7:0] b, input logic eoi);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eoi;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b0);
    endtask

    // Printable byte, mostly clear of the delimiter and the quote characters.
    function automatic logic [7:0] text_byte();
        logic [7:0] c;
        if ($urandom_range(0, 9) == 0)
            return CHR_SPACE;
        do
            c = 8'($urandom_range(33, 126));
        while (c == cur_delim || c == CHR_DQUOTE || c == CHR_SQUOTE);
        return c;
    endfunction

    function automatic logic [7:0] ws_byte();
        case ($urandom_range(0, 4))
            0:       return CHR_SPACE;
            1:       return CHR_TAB;
            2:       return CHR_CR;
            3:       return CHR_VT;
            default: return CHR_FF;
        endcase
    endfunction

    task automatic pad_trailing();
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 2)) send_word(ws_byte(), 1'b0);
    endtask

    task automatic send_field();
        int         shape;
        int         n;
        logic [7:0] q;
        // leading blanks get dropped by the block
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2))
                send_word($urandom_range(0, 1) ? CHR_SPACE : CHR_TAB, 1'b0);
        shape = $urandom_range(0, 9);
        q     = $urandom_range(0, 1) ? CHR_DQUOTE : CHR_SQUOTE;
        case (shape)
            0: ;  // empty field
            1, 2, 3, 4: begin
                repeat ($urandom_range(1, 6)) send_word(text_byte(), 1'b0);
                pad_trailing();
            end
            5, 6, 7: begin
                // quoted, with escaped quotes and delimiters inside
                send_word(q, 1'b0);
                n = $urandom_range(0, 5);
                repeat (n) begin
                    case ($urandom_range(0, 5))
                        0: begin
                            send_word(q, 1'b0);
                            send_word(q, 1'b0);
                        end
                        1:       send_word(cur_delim, 1'b0);
                        default: send_word(text_byte(), 1'b0);
                    endcase
                end
                send_word(q, 1'b0);
                if ($urandom_range(0, 7) == 0)
                    send_word(text_byte(), 1'b0);
                pad_trailing();
            end
            8: begin
                // around the store size, so that it overflows now and then
                n = $urandom_range(30, 40);
                if ($urandom_range(0, 1) == 1) begin
                    send_word(q, 1'b0);
                    repeat (n) send_word(text_byte(), 1'b0);
                    send_word(q, 1'b0);
                end else begin
                    repeat (n) send_word(text_byte(), 1'b0);
                end
                pad_trailing();
            end
            default: begin
                repeat ($urandom_range(1, 3)) send_word(ws_byte(), 1'b0);
            end
        endcase
    endtask

    task automatic send_record();
        int nf;
        nf = $urandom_range(1, 4);
        for (int f = 0; f < nf; f++) begin
            send_field();
            if (f < nf - 1)
                send_word(cur_delim, 1'b0);
        end
        case ($urandom_range(0, 5))
            0: begin
                send_word(CHR_CR, 1'b0);
                send_word(CHR_NL, 1'b0);
            end
            1:       send_word(8'($urandom_range(0, 255)), 1'b1);
            default: send_word(CHR_NL, 1'b0);
        endcase
    endtask

    task automatic run_random(input int n_items);
        int stop_at;
        int r;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            r = $urandom_range(0, 9);
            if (r < 7) begin
                send_record();
            end else if (r < 9) begin
                repeat ($urandom_range(1, 6))
                    send_word(($urandom_range(0, 3) == 0) ? CHR_NUL :
                              8'($urandom_range(0, 255)), 1'b0);
            end else begin
                send_word(8'($urandom_range(0, 255)), 1'b1);
            end
        end
    endtask

    // Drop valid and wait until every expected word is out and the block is
    // quiet, so that a register write lands while it is idle.
    task automatic settle(input int quiet);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (quiet) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] a,
                             input logic [CFG_DATA_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_phase(input logic [7:0] d);
        settle(SETTLE_CYCLES);
        write_reg(DELIM_ADDR, {{(CFG_DATA_W - 8){1'b0}}, d});
        cur_delim = d;
        run_random(PHASE_ITEMS);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed text under the reset delimiter: null skip, leading blanks,
        // double-quoted field with a delimiter and an escaped quote inside,
        // single-quoted field with whitespace after the closing quote,
        // delimiter before a newline, blank line, trailing VT/FF trim,
        // empty field, top byte value, end of stream carrying a stray byte.
        send_word(CHR_NUL, 1'b0);
        send_text(" \t\"a,\"\"\",'b' ");
        send_word(CHR_CR, 1'b0);
        send_text(",\n\nx");
        send_word(CHR_VT, 1'b0);
        send_word(CHR_FF, 1'b0);
        send_text(",,\n");
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b1);

        // First random phase carries the long receiver hold-off.
        hold_req <= 1'b1;
        run_random(PHASE_ITEMS);

        // Walk the delimiter through its extremes and odd choices, then back.
        run_phase(8'hFF);
        run_phase(8'h01);
        run_phase(8'h3B);
        run_phase(CHR_TAB);
        run_phase(CHR_DQUOTE);
        run_phase(DELIMITER_RESET);

        settle(DRAIN_CYCLES);
        if (errors == 0) begin
            $display("csv_field_tokenizer_tb: PASS");
        end else begin
            $display("csv_field_tokenizer_tb: FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/csvft_pkg.sv
src/csvft_ram.sv
src/csv_field_tokenizer.sv
tb/sv/csv_field_tokenizer_chk.sv
tb/sv/csv_field_tokenizer_tb.sv
